>>> hdl/mce_pkg.sv
package mce_pkg;

    localparam int CharWidth  = 8;
    localparam int NodeWidth  = 7;
    localparam int LevelWidth = 3;
    localparam int LenWidth   = 3;

    localparam logic [CharWidth-1:0] SpaceChar = 8'h20;

    localparam logic [LenWidth-1:0] LenDot        = 3'd1;
    localparam logic [LenWidth-1:0] LenDash       = 3'd3;
    localparam logic [LenWidth-1:0] LenGap        = 3'd1;
    localparam logic [LenWidth-1:0] LenCharSpace  = 3'd2;
    localparam logic [LenWidth-1:0] LenWordSpace  = 3'd6;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_MARK,
        ST_GAP,
        ST_FINAL
    } mce_state_t;

    typedef enum logic [1:0]
    {
        RUN_MARK,
        RUN_GAP,
        RUN_FINAL
    } run_kind_t;

    typedef struct packed
    {
        logic      load;
        logic      advance;
        run_kind_t kind;
    } dp_cmd_t;

    typedef struct packed
    {
        logic lvl_zero;
        logic lvl_one;
    } dp_status_t;

    // Heap position of a character in the Morse tree: the root is 0, the dot
    // child of n is 2n+1 and the dash child is 2n+2. Zero means no marks.
    function automatic logic [NodeWidth-1:0] node_of(input logic [CharWidth-1:0] raw);
        logic [CharWidth-1:0] folded;
        logic [NodeWidth-1:0] node;
        folded = raw;
        if (raw[6] && raw[5])
        begin
            folded[5] = 1'b0;
        end
        unique case (folded[6:0])
            7'h45: node = 7'd1;   // E
            7'h54: node = 7'd2;   // T
            7'h49: node = 7'd3;   // I
            7'h41: node = 7'd4;   // A
            7'h4E: node = 7'd5;   // N
            7'h4D: node = 7'd6;   // M
            7'h53: node = 7'd7;   // S
            7'h55: node = 7'd8;   // U
            7'h52: node = 7'd9;   // R
            7'h57: node = 7'd10;  // W
            7'h44: node = 7'd11;  // D
            7'h4B: node = 7'd12;  // K
            7'h47: node = 7'd13;  // G
            7'h4F: node = 7'd14;  // O
            7'h48: node = 7'd15;  // H
            7'h56: node = 7'd16;  // V
            7'h46: node = 7'd17;  // F
            7'h4C: node = 7'd19;  // L
            7'h50: node = 7'd21;  // P
            7'h4A: node = 7'd22;  // J
            7'h42: node = 7'd23;  // B
            7'h58: node = 7'd24;  // X
            7'h43: node = 7'd25;  // C
            7'h59: node = 7'd26;  // Y
            7'h5A: node = 7'd27;  // Z
            7'h51: node = 7'd28;  // Q
            7'h35: node = 7'd31;  // 5
            7'h34: node = 7'd32;  // 4
            7'h33: node = 7'd34;  // 3
            7'h32: node = 7'd38;  // 2
            7'h26: node = 7'd39;  // ampersand
            7'h2B: node = 7'd41;  // plus
            7'h31: node = 7'd46;  // 1
            7'h36: node = 7'd47;  // 6
            7'h3D: node = 7'd48;  // equals
            7'h2F: node = 7'd49;  // slash
            7'h28: node = 7'd53;  // open parenthesis
            7'h37: node = 7'd55;  // 7
            7'h38: node = 7'd59;  // 8
            7'h39: node = 7'd61;  // 9
            7'h30: node = 7'd62;  // 0
            7'h3F: node = 7'd75;  // question mark
            7'h5F: node = 7'd76;  // underscore
            7'h22: node = 7'd81;  // double quote
            7'h2E: node = 7'd84;  // period
            7'h40: node = 7'd89;  // at sign
            7'h27: node = 7'd93;  // apostrophe
            7'h2D: node = 7'd96;  // hyphen
            7'h3B: node = 7'd105; // semicolon
            7'h21: node = 7'd106; // exclamation mark
            7'h29: node = 7'd108; // close parenthesis
            7'h2C: node = 7'd114; // comma
            7'h3A: node = 7'd119; // colon, the filler entry at its last position
            default: node = 7'd0;
        endcase
        if (raw[7])
        begin
            node = 7'd0;
        end
        return node;
    endfunction

    // Tree depth of a node, which is also the number of symbols it encodes.
    function automatic logic [LevelWidth-1:0] depth_of(input logic [NodeWidth-1:0] node);
        logic [NodeWidth:0] n1;
        logic [LevelWidth-1:0] d;
        n1 = {1'b0, node} + 8'd1;
        priority if (n1[6]) d = 3'd6;
        else if (n1[5]) d = 3'd5;
        else if (n1[4]) d = 3'd4;
        else if (n1[3]) d = 3'd3;
        else if (n1[2]) d = 3'd2;
        else if (n1[1]) d = 3'd1;
        else d = 3'd0;
        return d;
    endfunction

endpackage

>>> hdl/morse_code_encoder_unit.sv
// Channel  Direction  Payload
// s_*      in         tdata[7:0] = char_code
// m_*      out        tdata[0] = tone_on, tdata[3:1] = length_units, tlast = last
//
// A character is loaded, then delivered as a mark run and a one-unit gap run per
// symbol, followed by its final space run.
// A character with no symbols passes through the mark state without offering a run before its final space.
// Reset returns the controller to idle; no character is held across reset.
// A stall on the result channel holds the current run and the input stays
// closed until the final space of the character has been transferred.
module morse_code_encoder_unit
    import mce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] tone_on, [3:1] length_units, [7:4] zero
    output logic       m_tlast
);

    dp_cmd_t             cmd;
    dp_status_t          status;
    logic                tone_on;
    logic [LenWidth-1:0] length_units;

    mce_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_last  (m_tlast),
        .status    (status),
        .cmd       (cmd)
    );

    mce_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_code    (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .tone_on      (tone_on),
        .length_units (length_units)
    );

    assign m_tdata = {4'b0000, length_units, tone_on};

    // Input and output never handshake in the same cycle.
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a run is offered");

    // A mark transfer is always followed by a one-unit space.
    a_mark_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tdata[0]) |=>
        (m_tvalid && !m_tdata[0] && m_tdata[3:1] == LenGap && !m_tlast))
        else $error("mark not followed by a gap");

    // The last run of a character reopens the input.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("input not reopened after last run");

    // A final space is never a mark.
    a_last_space: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> !m_tdata[0])
        else $error("last run carries a tone");

endmodule

>>> hdl/mce_datapath.sv
module mce_datapath
    import mce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CharWidth-1:0] char_code,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    output logic                 tone_on,
    output logic [LenWidth-1:0]  length_units
);

    logic [NodeWidth-1:0]  node_reg, node_next;
    logic [LevelWidth-1:0] lvl_reg, lvl_next;
    logic                  space_reg, space_next;

    logic [NodeWidth-1:0]  level_base;
    logic [NodeWidth-1:0]  offset;
    logic                  dash;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg <= '0;
        end
        else
        begin
            lvl_reg <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        space_reg <= space_next;
    end

    always_comb
    begin
        node_next  = node_reg;
        lvl_next   = lvl_reg;
        space_next = space_reg;
        priority if (cmd.load)
        begin
            node_next  = node_of(char_code);
            lvl_next   = depth_of(node_of(char_code));
            space_next = (char_code == SpaceChar);
        end
        else if (cmd.advance)
        begin
            lvl_next = lvl_reg - 3'd1;
        end
    end

    // The symbol at a level is the bit of the node's offset from the first
    // node of that level, taken at the level's weight.
    assign level_base = (7'd1 << lvl_reg) - 7'd1;
    assign offset     = node_reg - level_base;
    assign dash       = offset[lvl_reg - 3'd1];

    assign status.lvl_zero = (lvl_reg == 3'd0);
    assign status.lvl_one  = (lvl_reg == 3'd1);

    always_comb
    begin
        unique case (cmd.kind)
            RUN_MARK:
            begin
                tone_on      = 1'b1;
                length_units = dash ? LenDash : LenDot;
            end
            RUN_GAP:
            begin
                tone_on      = 1'b0;
                length_units = LenGap;
            end
            RUN_FINAL:
            begin
                tone_on      = 1'b0;
                length_units = space_reg ? LenWordSpace : LenCharSpace;
            end
            default:
            begin
                tone_on      = 1'b0;
                length_units = LenGap;
            end
        endcase
    end

endmodule

>>> hdl/mce_controller.sv
module mce_controller
    import mce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_last,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    mce_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // The depth is not loaded yet, so the choice is made in the
                    // first run state through the zero-level check below.
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                if (status.lvl_zero)
                begin
                    state_next = ST_FINAL;
                end
                else if (out_ready)
                begin
                    state_next = ST_GAP;
                end
            end
            ST_GAP:
            begin
                if (out_ready)
                begin
                    state_next = status.lvl_one ? ST_FINAL : ST_MARK;
                end
            end
            ST_FINAL:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        out_last    = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        cmd.kind    = RUN_GAP;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MARK:
            begin
                out_valid = !status.lvl_zero;
                cmd.kind  = RUN_MARK;
            end
            ST_GAP:
            begin
                out_valid   = 1'b1;
                cmd.kind    = RUN_GAP;
                cmd.advance = out_ready;
            end
            ST_FINAL:
            begin
                out_valid = 1'b1;
                out_last  = 1'b1;
                cmd.kind  = RUN_FINAL;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> bench/tb_morse_code_encoder_unit.sv
`timescale 1ns / 1ps

module tb_morse_code_encoder_unit;
    import mce_pkg::*;

    localparam int QuietLimit = 4000;
    localparam int ItemsPerPhase = 39;
    localparam int DrainCycles = 32;

    typedef struct packed
    {
        logic                tone;
        logic [LenWidth-1:0] len;
        logic                fin;
    } morse_run_t;

    // Expected run sequence per character, derived from its position in the Morse tree.
    class morse_scoreboard;
        string        tree;
        morse_run_t   runs_due[$];
        int           mismatches;

        function new();
            tree = {" ETIANMSURWDKGOHVF:L:PJBXCYZQ::54:3:::2&:+::::16=/:::(:7:::8:90",
                    "::::::::::::?_::::\"::.::::@:::'::-::::::::;!:):::::,:::::"};
            mismatches = 0;
        endfunction

        // The last matching position wins, so the filler character gets the deepest slot.
        function int tree_position(logic [CharWidth-1:0] raw);
            logic [CharWidth-1:0] folded;
            folded = raw;
            if (raw[6] && raw[5])
            begin
                folded[5] = 1'b0;
            end
            if (folded == 8'd0 || folded[7])
            begin
                return 0;
            end
            for (int n = tree.len() - 1; n >= 1; n--)
            begin
                if (tree[n] == folded)
                begin
                    return n;
                end
            end
            return 0;
        endfunction

        function void note_char(logic [CharWidth-1:0] raw);
            int         pos;
            bit         dashes[$];
            morse_run_t r;
            pos = tree_position(raw);
            // Climb to the root; an even position is a dash child.
            while (pos != 0)
            begin
                dashes.push_front(pos % 2 == 0);
                pos = (pos - 1) / 2;
            end
            foreach (dashes[i])
            begin
                r = '{tone: 1'b1, len: dashes[i] ? LenDash : LenDot, fin: 1'b0};
                runs_due.push_back(r);
                r = '{tone: 1'b0, len: LenGap, fin: 1'b0};
                runs_due.push_back(r);
            end
            r = '{tone: 1'b0, len: (raw == SpaceChar) ? LenWordSpace : LenCharSpace,
                  fin: 1'b1};
            runs_due.push_back(r);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: %s", $realtime, what);
            end
        endfunction

        function void check_run(logic [7:0] tdata, logic tlast);
            morse_run_t want;
            morse_run_t got;
            got = '{tone: tdata[0], len: tdata[3:1], fin: tlast};
            if (runs_due.size() == 0)
            begin
                flag($sformatf("unexpected run tone=%b len=%0d last=%b",
                               got.tone, got.len, got.fin));
                return;
            end
            want = runs_due.pop_front();
            if (got.tone !== want.tone)
            begin
                flag($sformatf("tone_on: expected %b, got %b", want.tone, got.tone));
            end
            if (got.len !== want.len)
            begin
                flag($sformatf("length_units: expected %0d, got %0d", want.len, got.len));
            end
            if (got.fin !== want.fin)
            begin
                flag($sformatf("last: expected %b, got %b", want.fin, got.fin));
            end
            if (tdata[7:4] !== 4'd0)
            begin
                flag($sformatf("tdata padding: expected 0, got %h", tdata[7:4]));
            end
        endfunction

        function int pending();
            return runs_due.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    morse_scoreboard sb = new();

    string known_chars = "ETIANMSURWDKGOHVFLPJBXCYZQ5432&+16=/(7890?_\".@'-;!),:";

    logic [7:0] directed_chars [25] = '{
        8'h00, 8'hFF, 8'h80, 8'h20, 8'h45, 8'h54, 8'h35, 8'h30, 8'h3F, 8'h29,
        8'h3A, 8'h61, 8'h7A, 8'h60, 8'h7F, 8'h5F, 8'h23, 8'h7B, 8'hC5, 8'hE1,
        8'h2C, 8'h21, 8'h40, 8'h22, 8'h0A
    };

    morse_code_encoder_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Note accepted characters before checking, so a same-edge run can never race ahead.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            sb.note_char(s_tdata);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_run(m_tdata, m_tlast);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QuietLimit)
        begin
            $display("tb_morse_code_encoder_unit: done, errors");
            $finish;
        end
    end

    task automatic send_char(logic [7:0] c);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        if ($urandom_range(99) < 30)
        begin
            return 8'($urandom_range(255));
        end
        c = known_chars[$urandom_range(known_chars.len() - 1)];
        // Lowercase half of the letters to exercise the case folding.
        if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1))
        begin
            c[5] = 1'b1;
        end
        return c;
    endfunction

    // The extra edge lets the monitor note the last accepted character first.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            if (ph == 0)
            begin
                foreach (directed_chars[i])
                begin
                    send_char(directed_chars[i]);
                end
            end
            for (int i = 0; i < ItemsPerPhase; i++)
            begin
                send_char(pick_char());
            end
            drain();
        end

        repeat (DrainCycles) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("tb_morse_code_encoder_unit: done, clean");
        end
        else
        begin
            $display("tb_morse_code_encoder_unit: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/mce_pkg.sv
hdl/mce_datapath.sv
hdl/mce_controller.sv
hdl/morse_code_encoder_unit.sv
bench/tb_morse_code_encoder_unit.sv
